/* sv/sliding_window_maximum_unit_assert.svh */
// ----------------------------------------------------------------------------
// Sliding window maximum: assertion macros
// Shared concurrent assertion forms, clocked on clock and idle in reset.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MAXIMUM_UNIT_ASSERT_SVH
`define SLIDING_WINDOW_MAXIMUM_UNIT_ASSERT_SVH

// condition holds at every edge
`define SWM_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequence holds at the same edge
`define SWM_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequence holds at the next edge
`define SWM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/swm_pkg.sv */
// ----------------------------------------------------------------------------
// Sliding window maximum: package
// Sizes, types and helper functions shared by the cell chain and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

   localparam int WINDOW_MAX = 64;
   localparam int CELL_COUNT = WINDOW_MAX;
   localparam int SAMPLE_W   = 32;
   localparam int WS_W       = 7;
   localparam int POS_MOD    = 2 * WINDOW_MAX;
   localparam int POS_W      = $clog2(POS_MOD);
   localparam int POS_X_W    = POS_W + 1;
   localparam int K_W        = $clog2(WINDOW_MAX + 1);
   localparam int CMP_W      = (POS_W > K_W) ? POS_W : K_W;
   localparam logic [WS_W-1:0] WS_RESET = WS_W'(4);

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [POS_W-1:0]           pos_type;
   typedef logic [K_W-1:0]             win_type;
   typedef logic [WS_W-1:0]            ws_type;

   typedef struct packed {
      logic load;
      logic trim;
      logic shift;
      logic flush;
   } cell_ctl_type;

   typedef struct packed {
      logic       valid;
      logic       keep;
      sample_type value;
      pos_type    pos;
   } cell_out_type;

   function automatic win_type eff_window(ws_type ws);
      win_type k;
      if (ws == '0) begin
         k = win_type'(1);
      end else if (int'(ws) > WINDOW_MAX) begin
         k = win_type'(WINDOW_MAX);
      end else begin
         k = win_type'(ws);
      end
      return k;
   endfunction

   function automatic pos_type pos_age(pos_type now, pos_type then_pos);
      logic [POS_X_W-1:0] d;
      if (now >= then_pos) begin
         d = {1'b0, now} - {1'b0, then_pos};
      end else begin
         d = {1'b0, now} + POS_X_W'(POS_MOD) - {1'b0, then_pos};
      end
      return d[POS_W-1:0];
   endfunction

   function automatic logic is_expired(pos_type now, pos_type then_pos, win_type k);
      pos_type age;
      age = pos_age(now, then_pos);
      return CMP_W'(age) >= CMP_W'(k);
   endfunction

   function automatic pos_type pos_next(pos_type p);
      pos_type r;
      if (p == pos_type'(POS_MOD - 1)) begin
         r = '0;
      end else begin
         r = p + pos_type'(1);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* sv/swm_if.sv */
// ----------------------------------------------------------------------------
// Sliding window maximum: channel interfaces
// Valid/ready channels for sample requests and window maximum responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface swm_req_if;
   logic                 valid;
   logic                 ready;
   swm_pkg::sample_type  sample;
   logic                 first_item;

   modport source (output valid, output sample, output first_item, input ready);
   modport sink   (input valid, input sample, input first_item, output ready);
endinterface

interface swm_rsp_if;
   logic                 valid;
   logic                 ready;
   swm_pkg::sample_type  window_max;

   modport source (output valid, output window_max, input ready);
   modport sink   (input valid, input window_max, output ready);
endinterface

`default_nettype wire

/* sv/swm_cell.sv */
// ----------------------------------------------------------------------------
// Sliding window maximum: queue cell
// One slot of the monotonic queue; keeps, shifts in or takes the new sample.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  swm_pkg::cell_ctl_type  ctl,
   input  swm_pkg::sample_type    new_value,
   input  swm_pkg::pos_type       new_pos,
   input  swm_pkg::cell_out_type  right,
   input  logic                   prev_keep,
   input  logic                   prev_keep_shift,
   output swm_pkg::cell_out_type  state,
   output swm_pkg::sample_type    next_value
);

   logic                 valid_ff;
   logic                 valid_in;
   swm_pkg::sample_type  value_ff;
   swm_pkg::sample_type  value_in;
   swm_pkg::pos_type     pos_ff;
   swm_pkg::pos_type     pos_in;
   logic                 keep;

   assign keep = valid_ff && !ctl.flush && (value_ff > new_value);

   always_comb begin
      logic                take_src;
      logic                prev;
      swm_pkg::sample_type src_value;
      swm_pkg::pos_type    src_pos;
      valid_in = valid_ff;
      value_in = value_ff;
      pos_in   = pos_ff;
      if (ctl.shift) begin
         take_src  = right.keep;
         prev      = prev_keep_shift;
         src_value = right.value;
         src_pos   = right.pos;
      end else begin
         take_src  = keep;
         prev      = prev_keep;
         src_value = value_ff;
         src_pos   = pos_ff;
      end
      if (ctl.trim) begin
         valid_in = right.valid;
         value_in = right.value;
         pos_in   = right.pos;
      end else if (ctl.load) begin
         if (take_src) begin
            valid_in = 1'b1;
            value_in = src_value;
            pos_in   = src_pos;
         end else if (prev) begin
            valid_in = 1'b1;
            value_in = new_value;
            pos_in   = new_pos;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      pos_ff   <= pos_in;
   end

   assign state.valid = valid_ff;
   assign state.keep  = keep;
   assign state.value = value_ff;
   assign state.pos   = pos_ff;
   assign next_value  = value_in;

endmodule

`default_nettype wire

/* sv/sliding_window_maximum_unit.sv */
// ----------------------------------------------------------------------------
// Sliding window maximum unit
// Monotonic queue of candidate maxima held in a chain of cells.
//
// Usage:
//   req_if carries one signed sample per request and a first_item flag that
//   starts a new sequence. rsp_if returns the maximum of the last
//   window_size samples once the window of the current sequence has filled;
//   earlier requests give no response. csr_wr_en/csr_wr_data set
//   window_size (0 acts as 1, sizes above 64 act as 64); write it only
//   while the unit is idle.
//   A response is registered: it is valid in the cycle after its request is accepted.
//   Throughput: one request per cycle while the window size is unchanged and no response stalls.
//   After window_size shrinks, the chain drops one expired front cell per
//   cycle, holding req_if.ready low, until at most the head has expired;
//   the head then leaves with the next request.
//   Reset empties the queue, clears the counters and sets window_size to 4.
//   A stalled response holds in its register; req_if.ready drops until it
//   is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_maximum_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  swm_pkg::ws_type       csr_wr_data,
   swm_req_if.sink               req_if,
   swm_rsp_if.source             rsp_if
);

   `include "sliding_window_maximum_unit_assert.svh"

   localparam int N    = swm_pkg::CELL_COUNT;
   localparam int IDX1 = (N > 1) ? 1 : 0;

   swm_pkg::ws_type       window_size_ff;
   swm_pkg::pos_type      pc_ff;
   swm_pkg::pos_type      pc_in;
   swm_pkg::win_type      seen_ff;
   swm_pkg::win_type      seen_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   swm_pkg::sample_type   rsp_data_ff;
   swm_pkg::sample_type   rsp_data_in;

   swm_pkg::win_type      k;
   swm_pkg::cell_ctl_type ctl;
   swm_pkg::cell_out_type cell_out [N];
   swm_pkg::sample_type   head_next;
   swm_pkg::pos_type      new_pos;
   logic [N-1:0]          valid_vec;
   logic [N-1:0]          keep_vec;
   logic                  expired_head;
   logic                  trim;
   logic                  out_free;
   logic                  accept;
   logic                  first;
   logic                  emit;

   assign k     = swm_pkg::eff_window(window_size_ff);
   assign first = req_if.first_item;

   assign expired_head = valid_vec[0] && swm_pkg::is_expired(pc_ff, cell_out[0].pos, k);
   assign trim = (N > 1) && valid_vec[IDX1] &&
                 swm_pkg::is_expired(pc_ff, cell_out[IDX1].pos, k);

   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = !trim && out_free;
   assign accept       = req_if.valid && req_if.ready;
   assign new_pos      = first ? '0 : pc_ff;

   assign ctl.load  = accept;
   assign ctl.trim  = trim;
   assign ctl.shift = accept && !first && (expired_head || keep_vec[N-1]);
   assign ctl.flush = accept && first;

   genvar i;
   generate
      for (i = 0; i < N; i++) begin : g_cell
         swm_pkg::cell_out_type right;
         logic                  prev_keep;
         logic                  prev_keep_shift;

         if (i == N - 1) begin : g_tail
            assign right = '0;
         end else begin : g_link
            assign right = cell_out[i+1];
         end

         if (i == 0) begin : g_head
            assign prev_keep       = 1'b1;
            assign prev_keep_shift = 1'b1;
         end else begin : g_body
            assign prev_keep       = keep_vec[i-1];
            assign prev_keep_shift = keep_vec[i];
         end

         if (i == 0) begin : g_head_cell
            swm_cell u_cell (
               .clock           (clock),
               .reset           (reset),
               .ctl             (ctl),
               .new_value       (req_if.sample),
               .new_pos         (new_pos),
               .right           (right),
               .prev_keep       (prev_keep),
               .prev_keep_shift (prev_keep_shift),
               .state           (cell_out[i]),
               .next_value      (head_next)
            );
         end else begin : g_body_cell
            swm_cell u_cell (
               .clock           (clock),
               .reset           (reset),
               .ctl             (ctl),
               .new_value       (req_if.sample),
               .new_pos         (new_pos),
               .right           (right),
               .prev_keep       (prev_keep),
               .prev_keep_shift (prev_keep_shift),
               .state           (cell_out[i]),
               .next_value      ()
            );
         end

         assign valid_vec[i] = cell_out[i].valid;
         assign keep_vec[i]  = cell_out[i].keep;
      end
   endgenerate

   always_comb begin
      swm_pkg::win_type base;
      swm_pkg::win_type capped;
      base    = first ? '0 : seen_ff;
      capped  = (base > k) ? k : base;
      seen_in = seen_ff;
      pc_in   = pc_ff;
      emit    = 1'b0;
      if (accept) begin
         seen_in = (capped < k) ? capped + swm_pkg::win_type'(1) : capped;
         pc_in   = swm_pkg::pos_next(new_pos);
         emit    = (seen_in >= k);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept && emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = head_next;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= swm_pkg::WS_RESET;
         pc_ff          <= '0;
         seen_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            window_size_ff <= csr_wr_data;
         end
         pc_ff        <= pc_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.window_max = rsp_data_ff;

   `SWM_ASSERT_ALWAYS(a_valid_prefix, ((valid_vec + N'(1)) & valid_vec) == '0, "queue has a gap")
   `SWM_ASSERT_NEXT(a_head_filled, accept, valid_vec[0], "queue empty after a request")
   `SWM_ASSERT_NEXT(a_first_single, accept && first, valid_vec == N'(1), "new sequence not alone")
   `SWM_ASSERT_NEXT(a_rsp_head, accept && emit, rsp_data_ff == cell_out[0].value, "wrong response")

endmodule

`default_nettype wire

/* bench/sliding_window_maximum_unit_checker.sv */
// ----------------------------------------------------------------------------
// Sliding window maximum unit: response checker
// Watches the request, response and register ports, keeps its own monotonic
// queue of candidate maxima and compares every response with the oldest
// predicted window maximum.
// ----------------------------------------------------------------------------
module sliding_window_maximum_unit_checker
   import swm_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   swm_req_if     req_if,
   swm_rsp_if     rsp_if,
   input  logic   csr_wr_en,
   input  ws_type csr_wr_data,
   output int     mismatch_count,
   output int     outstanding_count
);

   typedef struct {
      sample_type value;
      pos_type    pos;
   } candidate_type;

   candidate_type candidates[$];
   sample_type    expected_maxima[$];
   pos_type       next_pos;
   int            samples_seen;
   ws_type        window_reg;

   function automatic int window_span(ws_type ws);
      if (ws == '0) begin
         return 1;
      end
      if (int'(ws) > WINDOW_MAX) begin
         return WINDOW_MAX;
      end
      return int'(ws);
   endfunction

   task automatic log_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t: %s", $time, what);
      end
   endtask

   task automatic advance_window(input sample_type s, input logic restart);
      int            k;
      candidate_type entry;
      k = window_span(window_reg);
      if (restart) begin
         candidates.delete();
         next_pos = '0;
         samples_seen = 0;
      end
      // drop expired entries from the front
      while (candidates.size() > 0 &&
             int'(pos_type'(next_pos - candidates[0].pos)) >= k) begin
         candidates.delete(0);
      end
      // drop dominated entries from the back, newest equal copy wins
      while (candidates.size() > 0 &&
             candidates[candidates.size() - 1].value <= s) begin
         candidates.delete(candidates.size() - 1);
      end
      if (candidates.size() >= WINDOW_MAX) begin
         candidates.delete(0);
      end
      entry.value = s;
      entry.pos   = next_pos;
      candidates.insert(candidates.size(), entry);
      next_pos = next_pos + 1'b1;
      if (samples_seen > k) begin
         samples_seen = k;
      end
      if (samples_seen < k) begin
         samples_seen++;
      end
      if (samples_seen >= k) begin
         expected_maxima.insert(expected_maxima.size(), candidates[0].value);
      end
   endtask

   always @(posedge clock) begin
      sample_type predicted;
      if (reset) begin
         candidates.delete();
         expected_maxima.delete();
         next_pos = '0;
         samples_seen = 0;
         window_reg = WS_RESET;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_maxima.size() == 0) begin
               log_mismatch($sformatf("window max mismatch: expected none, got %0d",
                                      rsp_if.window_max));
            end else begin
               predicted = expected_maxima[0];
               expected_maxima.delete(0);
               if (rsp_if.window_max !== predicted) begin
                  log_mismatch($sformatf("window max mismatch: expected %0d, got %0d",
                                         predicted, rsp_if.window_max));
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            advance_window(req_if.sample, req_if.first_item);
         end
         if (csr_wr_en) begin
            window_reg = csr_wr_data;
         end
      end
      outstanding_count <= expected_maxima.size();
   end

endmodule

/* bench/sliding_window_maximum_unit_tb.sv */
// ----------------------------------------------------------------------------
// Sliding window maximum unit: testbench
// Drives directed and random sample streams across a range of window sizes,
// with random idle cycles on both channels, and reports the checker verdict.
// ----------------------------------------------------------------------------
module sliding_window_maximum_unit_tb;
   import swm_pkg::*;

   typedef enum int {
      PATTERN_RANDOM,
      PATTERN_NARROW,
      PATTERN_RISING,
      PATTERN_FALLING,
      PATTERN_EXTREME
   } stream_pattern_type;

   localparam sample_type SAMPLE_HI = 32'sh7FFF_FFFF;
   localparam sample_type SAMPLE_LO = 32'sh8000_0000;
   localparam int         PHASES    = 10;
   localparam int         PHASE_LEN = 135;
   localparam ws_type     WINDOW_PLAN [PHASES] =
      '{7'd1, 7'd64, 7'd0, 7'd127, 7'd5, 7'd2, 7'd65, 7'd16, 7'd3, 7'd8};

   logic   clock;
   logic   reset;
   logic   csr_wr_en;
   ws_type csr_wr_data;
   logic   steady;
   int     mismatch_count;
   int     outstanding_count;

   swm_req_if req_if();
   swm_rsp_if rsp_if();

   sliding_window_maximum_unit dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_if      (req_if),
      .rsp_if      (rsp_if)
   );

   sliding_window_maximum_unit_checker max_check (
      .clock             (clock),
      .reset             (reset),
      .req_if            (req_if),
      .rsp_if            (rsp_if),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .mismatch_count    (mismatch_count),
      .outstanding_count (outstanding_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_if.ready <= steady || ($urandom_range(99) >= 16);
   end

   initial begin
      #2_000_000;
      $display("FAIL sliding_window_maximum_unit");
      $finish;
   end

   task automatic send_sample(input sample_type value, input logic restart);
      while (!steady && $urandom_range(99) < 16) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.sample     <= value;
      req_if.first_item <= restart;
      @(posedge clock);
      while (!req_if.ready) begin
         @(posedge clock);
      end
   endtask

   task automatic settle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (outstanding_count != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic set_window(input ws_type size);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= size;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic run_stream(input int count, input logic restart_first);
      sample_type         value;
      stream_pattern_type pattern;
      int                 left;
      logic               restart;
      value = '0;
      left  = 0;
      pattern = PATTERN_RANDOM;
      for (int i = 0; i < count; i++) begin
         if (left == 0) begin
            pattern = stream_pattern_type'($urandom_range(4));
            left = ($urandom_range(3) == 0) ? $urandom_range(40, 90) : $urandom_range(3, 24);
         end
         left--;
         case (pattern)
            PATTERN_RANDOM: value = $urandom;
            PATTERN_NARROW: value = sample_type'($urandom_range(6)) - 3;
            PATTERN_RISING: value = value + sample_type'($urandom_range(3));
            PATTERN_FALLING: value = value - sample_type'($urandom_range(3));
            default: begin
               case ($urandom_range(3))
                  0: value = SAMPLE_HI;
                  1: value = SAMPLE_LO;
                  2: value = '0;
                  default: value = -1;
               endcase
            end
         endcase
         restart = (i == 0) ? restart_first : ($urandom_range(99) < 2);
         send_sample(value, restart);
      end
   endtask

   initial begin
      reset             = 1'b1;
      steady            = 1'b0;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      req_if.valid      = 1'b0;
      req_if.sample     = '0;
      req_if.first_item = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset window of four: extremes, equal values, restart mid-sequence
      send_sample(SAMPLE_HI, 1'b1);
      send_sample(SAMPLE_LO, 1'b0);
      send_sample('0, 1'b0);
      send_sample(-1, 1'b0);
      send_sample(5, 1'b0);
      send_sample(5, 1'b0);
      send_sample(5, 1'b0);
      send_sample(SAMPLE_LO, 1'b0);
      send_sample(4, 1'b0);
      send_sample(3, 1'b0);
      send_sample(9, 1'b1);
      send_sample(8, 1'b0);
      send_sample(7, 1'b0);
      send_sample(6, 1'b0);

      // shrink mid-sequence
      settle();
      set_window(7'd2);
      send_sample(1, 1'b0);
      send_sample(SAMPLE_LO, 1'b0);
      send_sample(-2, 1'b0);

      // grow mid-sequence
      settle();
      set_window(7'd6);
      send_sample(-3, 1'b0);
      send_sample(-4, 1'b0);
      send_sample(SAMPLE_HI, 1'b0);

      // zero acts as a window of one
      settle();
      set_window(7'd0);
      send_sample(SAMPLE_LO, 1'b0);
      send_sample(SAMPLE_HI, 1'b1);
      send_sample(-1, 1'b0);

      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         set_window((phase == PHASES - 1) ? ws_type'($urandom_range(127)) : WINDOW_PLAN[phase]);
         steady = (phase == 4);
         run_stream(PHASE_LEN, 1'($urandom_range(1)));
      end
      steady = 1'b0;

      req_if.valid <= 1'b0;
      @(posedge clock);
      for (int n = 0; n < 1000 && outstanding_count != 0; n++) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && outstanding_count == 0) begin
         $display("PASS sliding_window_maximum_unit");
      end else begin
         $display("FAIL sliding_window_maximum_unit");
      end
      $finish;
   end

endmodule
